>>> src/lcm_pkg.sv
// Shared types and constants of the lagged covariance matrix block.
package lcm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CORR_W     = 48;
    localparam int FRAC_SHIFT = 19;
    localparam int MEAN_W     = 33;
    localparam int D_W        = 34;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAG           = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ENABLE = 2'd3;

    localparam logic [CORR_W-1:0] CORR_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [CORR_W-1:0] CORR_NEG_MAG = 48'h8000_0000_0000;

    typedef struct packed {
        logic valid;
        logic first;
    } lcm_ctl_t;

endpackage

>>> src/lcm_ram.sv
// Generic RAM: one write port, two registered read ports.
module lcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

>>> src/lcm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lcm_div #(
    parameter int DW = 80,
    parameter int VW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNW = $clog2(DW + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [VW-1:0]  rem_reg, rem_next;
    logic [VW-1:0]  dvs_reg, dvs_next;
    logic [VW:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = VW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNW'(1);
            if (cnt_reg == CNW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

>>> src/lcm_cell.sv
// One column cell: centers its own channel, forms the lagged products and accumulates.
module lcm_cell #(
    parameter int NCH   = 8,
    parameter int J     = 0,
    parameter int ACC_W = 80
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lcm_pkg::lcm_ctl_t               in_ctl,
    input  logic signed [lcm_pkg::D_W-1:0]  in_di_a,
    input  logic signed [lcm_pkg::D_W-1:0]  in_di_b,
    input  logic [NCH*16-1:0]               in_lanes_a,
    input  logic [NCH*16-1:0]               in_lanes_b,
    input  logic signed [lcm_pkg::MEAN_W-1:0] mean_j,
    output lcm_pkg::lcm_ctl_t               out_ctl,
    output logic signed [lcm_pkg::D_W-1:0]  out_di_a,
    output logic signed [lcm_pkg::D_W-1:0]  out_di_b,
    output logic [NCH*16-1:0]               out_lanes_a,
    output logic [NCH*16-1:0]               out_lanes_b,
    output logic signed [ACC_W-1:0]         acc
);
    import lcm_pkg::*;

    localparam int PW = 2 * D_W;

    logic signed [SAMPLE_W-1:0] xa, xb;
    logic signed [D_W-1:0]      dj_a, dj_b;
    logic signed [PW-1:0]       pa_next, pb_next;
    logic signed [PW-1:0]       pa_reg, pb_reg;
    lcm_ctl_t                   pctl_reg, octl_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [D_W-1:0]      odia_reg, odib_reg;
    logic [NCH*16-1:0]          ola_reg, olb_reg;

    always_comb
    begin
        xa      = $signed(in_lanes_a[J*16 +: 16]);
        xb      = $signed(in_lanes_b[J*16 +: 16]);
        dj_a    = (D_W'(xa) <<< 16) - D_W'(mean_j);
        dj_b    = (D_W'(xb) <<< 16) - D_W'(mean_j);
        pa_next = in_di_a * dj_b;
        pb_next = dj_a * in_di_b;
        acc_next = acc_reg;
        if (pctl_reg.valid)
        begin
            acc_next = (pctl_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(pa_reg)
                       + ACC_W'(pb_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pctl_reg <= '0;
            octl_reg <= '0;
        end
        else
        begin
            pctl_reg <= in_ctl;
            octl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        acc_reg  <= acc_next;
        odia_reg <= in_di_a;
        odib_reg <= in_di_b;
        ola_reg  <= in_lanes_a;
        olb_reg  <= in_lanes_b;
    end

    assign out_ctl     = octl_reg;
    assign out_di_a    = odia_reg;
    assign out_di_b    = odib_reg;
    assign out_lanes_a = ola_reg;
    assign out_lanes_b = olb_reg;
    assign acc         = acc_reg;
endmodule

>>> src/lagged_covariance_matrix_top.sv
// Loading: one item per cycle while in the load state; s_tready is low during compute. After the
// last sample: C mean divisions (with centering), then per row N-lag time steps through the
// cell chain and per entry one division in the shared divider (both skipped when lag >= N).
// Reset clears positions, channel sums and handshakes and loads the registers with 2, 4096,
// 1 and 1; the sample memory is left unset and needs no clearing pass.
module lagged_covariance_matrix_top #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_SAMPLES  = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lcm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcm_pkg::TDATA_IN_W-1:0]      s_tdata,  // [15:0] sample_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcm_pkg::TDATA_OUT_W-1:0]     m_tdata,  // [47:0] corr_value, [50:48] row_index, [53:51] col_index
    output logic                                m_tuser,  // [0] lag_error
    output logic                                m_tlast
);
    import lcm_pkg::*;

    localparam int CIW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CCW    = $clog2(MAX_CHANNELS + 1);
    localparam int TW     = $clog2(MAX_SAMPLES);
    localparam int NW     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_W + TW + 1;
    localparam int ACC_W  = 68 + TW;
    localparam int WORD_W = MAX_CHANNELS * SAMPLE_W;
    localparam int DRAIN  = MAX_CHANNELS + 4;
    localparam int DRW    = $clog2(DRAIN + 1);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_MEAN  = 3'd1;
    localparam logic [2:0] ST_MWAIT = 3'd2;
    localparam logic [2:0] ST_FEED  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_DWAIT = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    // Configuration registers
    logic [3:0]  chan_cnt_reg;
    logic [12:0] samp_cnt_reg;
    logic [11:0] lag_reg;
    logic        center_reg;
    logic        geom_write;

    logic [CCW-1:0] cc;
    logic [NW-1:0]  ns;
    logic [NW-1:0]  span;
    logic           err;

    always_comb
    begin
        if (chan_cnt_reg == 4'd0)
            cc = CCW'(1);
        else if (chan_cnt_reg > MAX_CHANNELS)
            cc = CCW'(MAX_CHANNELS);
        else
            cc = CCW'(chan_cnt_reg);
        if (samp_cnt_reg == 13'd0)
            ns = NW'(1);
        else if (samp_cnt_reg > MAX_SAMPLES)
            ns = NW'(MAX_SAMPLES);
        else
            ns = NW'(samp_cnt_reg);
        err  = (32'(lag_reg) >= 32'(ns));
        span = NW'(32'(ns) - 32'(lag_reg));
    end

    assign geom_write = cfg_we && (cfg_index == REG_CHANNEL_COUNT ||
                                   cfg_index == REG_SAMPLE_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cnt_reg <= 4'd2;
            samp_cnt_reg <= 13'd4096;
            lag_reg      <= 12'd1;
            center_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT: chan_cnt_reg <= cfg_data[3:0];
                REG_SAMPLE_COUNT:  samp_cnt_reg <= cfg_data[12:0];
                REG_LAG:           lag_reg      <= cfg_data[11:0];
                REG_CENTER_ENABLE: center_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Sequencer state
    logic [2:0]      state_reg, state_next;
    logic [CIW-1:0]  cpos_reg, cpos_next;
    logic [TW-1:0]   tpos_reg, tpos_next;
    logic [CIW-1:0]  k_reg, k_next;
    logic [CIW-1:0]  row_reg, row_next;
    logic [NW-1:0]   t_reg, t_next;
    logic [DRW-1:0]  drain_reg, drain_next;
    logic            restart;

    logic signed [SUM_W-1:0]  sum_reg [MAX_CHANNELS];
    logic signed [MEAN_W-1:0] mean_reg [MAX_CHANNELS];
    logic [SAMPLE_W-1:0]      stage_reg [MAX_CHANNELS];

    logic                 s_fire, last_chan, last_step;
    logic                 ram_we;
    logic [WORD_W-1:0]    ram_wdata;
    logic [TW-1:0]        rd_addr_a, rd_addr_b;
    logic [WORD_W-1:0]    rd_data_a, rd_data_b;
    lcm_ctl_t             rd_ctl_next, rd_ctl_reg;

    logic                 div_start;
    logic [ACC_W-1:0]     div_dividend;
    logic [NW-1:0]        div_divisor;
    logic                 div_done;
    logic [ACC_W-1:0]     div_quot;
    logic                 neg_reg, neg_next;
    logic                 mean_wr;
    logic signed [MEAN_W-1:0] mean_val;

    logic [CORR_W-1:0]    res_reg, res_next;
    logic [ACC_W-1:0]     qshift;
    logic [CORR_W-1:0]    mag;

    logic                 out_load;
    logic                 m_tvalid_reg;
    logic [CORR_W-1:0]    o_corr_reg;
    logic [2:0]           o_row_reg, o_col_reg;
    logic                 o_err_reg, o_last_reg;

    logic signed [SUM_W-1:0]  sum_k;
    logic [SUM_W-1:0]         sum_mag;
    logic signed [ACC_W-1:0]  acc_k;
    logic [ACC_W-1:0]         acc_mag;
    logic signed [ACC_W-1:0]  cell_acc [MAX_CHANNELS];
    logic                     k_last, row_last;

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_fire    = s_tvalid && s_tready;
    assign last_chan = (CCW'(cpos_reg) + CCW'(1) == cc);
    assign last_step = (NW'(tpos_reg) + NW'(1) == ns);
    assign k_last    = (CCW'(k_reg) + CCW'(1) == cc);
    assign row_last  = (CCW'(row_reg) + CCW'(1) == cc);

    // A time step is gathered in a staging register and written as one memory word.
    always_comb
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            ram_wdata[c*SAMPLE_W +: SAMPLE_W] = (c == int'(cpos_reg)) ? s_tdata : stage_reg[c];
        end
        ram_we = s_fire && last_chan;
    end

    lcm_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_SAMPLES)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (tpos_reg),
        .wdata   (ram_wdata),
        .raddr_a (rd_addr_a),
        .rdata_a (rd_data_a),
        .raddr_b (rd_addr_b),
        .rdata_b (rd_data_b)
    );

    always_comb
    begin
        sum_k   = sum_reg[k_reg];
        sum_mag = sum_k[SUM_W-1] ? SUM_W'(-sum_k) : SUM_W'(sum_k);
        acc_k   = cell_acc[k_reg];
        acc_mag = acc_k[ACC_W-1] ? ACC_W'(-acc_k) : ACC_W'(acc_k);
        qshift  = div_quot >> FRAC_SHIFT;
        mean_val = neg_reg ? -MEAN_W'(div_quot) : MEAN_W'(div_quot);
        if (neg_reg)
        begin
            mag      = (qshift > ACC_W'(CORR_NEG_MAG)) ? CORR_NEG_MAG : qshift[CORR_W-1:0];
            res_next = CORR_W'(-mag);
        end
        else
        begin
            mag      = (qshift > ACC_W'(CORR_POS_MAX)) ? CORR_POS_MAX : qshift[CORR_W-1:0];
            res_next = mag;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cpos_next    = cpos_reg;
        tpos_next    = tpos_reg;
        k_next       = k_reg;
        row_next     = row_reg;
        t_next       = t_reg;
        drain_next   = drain_reg;
        neg_next     = neg_reg;
        restart      = 1'b0;
        div_start    = 1'b0;
        div_dividend = ACC_W'(sum_mag) << 16;
        div_divisor  = ns;
        mean_wr      = 1'b0;
        rd_ctl_next  = '0;
        rd_addr_a    = TW'(t_reg);
        rd_addr_b    = TW'(32'(t_reg) + 32'(lag_reg));
        out_load     = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_fire)
                begin
                    if (!last_chan)
                        cpos_next = cpos_reg + CIW'(1);
                    else
                    begin
                        cpos_next = '0;
                        if (!last_step)
                            tpos_next = tpos_reg + TW'(1);
                        else
                        begin
                            k_next     = '0;
                            state_next = ST_MEAN;
                        end
                    end
                end
            end
            ST_MEAN, ST_MWAIT:
            begin
                if (state_reg == ST_MEAN && center_reg)
                begin
                    div_start  = 1'b1;
                    neg_next   = sum_k[SUM_W-1];
                    state_next = ST_MWAIT;
                end
                else if (state_reg == ST_MEAN || div_done)
                begin
                    mean_wr = 1'b1;
                    if (k_last)
                    begin
                        k_next     = '0;
                        row_next   = '0;
                        t_next     = '0;
                        state_next = err ? ST_EMIT : ST_FEED;
                    end
                    else
                    begin
                        k_next     = k_reg + CIW'(1);
                        state_next = ST_MEAN;
                    end
                end
            end
            ST_FEED:
            begin
                rd_ctl_next.valid = 1'b1;
                rd_ctl_next.first = (t_reg == '0);
                t_next = t_reg + NW'(1);
                if (t_reg + NW'(1) == span)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + DRW'(1);
                if (drain_reg == DRW'(DRAIN))
                begin
                    k_next     = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = acc_mag;
                div_divisor  = span;
                neg_next     = acc_k[ACC_W-1];
                state_next   = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (k_last)
                    begin
                        k_next = '0;
                        if (row_last)
                        begin
                            restart    = 1'b1;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            row_next   = row_reg + CIW'(1);
                            t_next     = '0;
                            state_next = err ? ST_EMIT : ST_FEED;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + CIW'(1);
                        state_next = err ? ST_EMIT : ST_DIV;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (geom_write)
        begin
            restart = 1'b1;
        end
        if (restart)
        begin
            cpos_next = '0;
            tpos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            cpos_reg     <= '0;
            tpos_reg     <= '0;
            k_reg        <= '0;
            row_reg      <= '0;
            t_reg        <= '0;
            drain_reg    <= '0;
            rd_ctl_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cpos_reg   <= cpos_next;
            tpos_reg   <= tpos_next;
            k_reg      <= k_next;
            row_reg    <= row_next;
            t_reg      <= t_next;
            drain_reg  <= drain_next;
            rd_ctl_reg <= rd_ctl_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                if (restart)
                    sum_reg[c] <= '0;
                else if (s_fire && c == int'(cpos_reg))
                    sum_reg[c] <= sum_reg[c] + SUM_W'($signed(s_tdata));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        if (div_done)
            res_reg <= res_next;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            if (s_fire && c == int'(cpos_reg))
                stage_reg[c] <= s_tdata;
            if (mean_wr && c == int'(k_reg))
                mean_reg[c] <= center_reg ? mean_val : MEAN_W'(0);
        end
        if (out_load)
        begin
            o_corr_reg <= err ? CORR_W'(0) : res_reg;
            o_row_reg  <= 3'(row_reg);
            o_col_reg  <= 3'(k_reg);
            o_err_reg  <= err;
            o_last_reg <= k_last && row_last;
        end
    end

    lcm_div #(
        .DW(ACC_W),
        .VW(NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Head of the cell chain: the row channel is centered once and travels with both words.
    lcm_ctl_t              chain_ctl   [MAX_CHANNELS+1];
    logic signed [D_W-1:0] chain_di_a  [MAX_CHANNELS+1];
    logic signed [D_W-1:0] chain_di_b  [MAX_CHANNELS+1];
    logic [WORD_W-1:0]     chain_ln_a  [MAX_CHANNELS+1];
    logic [WORD_W-1:0]     chain_ln_b  [MAX_CHANNELS+1];

    lcm_ctl_t              head_ctl_reg;
    logic signed [D_W-1:0] head_di_a_reg, head_di_b_reg;
    logic [WORD_W-1:0]     head_ln_a_reg, head_ln_b_reg;
    logic signed [SAMPLE_W-1:0] xi_a, xi_b;
    logic signed [MEAN_W-1:0]   mean_i;

    always_comb
    begin
        xi_a   = $signed(rd_data_a[row_reg*SAMPLE_W +: SAMPLE_W]);
        xi_b   = $signed(rd_data_b[row_reg*SAMPLE_W +: SAMPLE_W]);
        mean_i = mean_reg[row_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_ctl_reg <= '0;
        else
            head_ctl_reg <= rd_ctl_reg;
    end

    always_ff @(posedge clk)
    begin
        head_di_a_reg <= (D_W'(xi_a) <<< 16) - D_W'(mean_i);
        head_di_b_reg <= (D_W'(xi_b) <<< 16) - D_W'(mean_i);
        head_ln_a_reg <= rd_data_a;
        head_ln_b_reg <= rd_data_b;
    end

    assign chain_ctl[0]  = head_ctl_reg;
    assign chain_di_a[0] = head_di_a_reg;
    assign chain_di_b[0] = head_di_b_reg;
    assign chain_ln_a[0] = head_ln_a_reg;
    assign chain_ln_b[0] = head_ln_b_reg;

    for (genvar g = 0; g < MAX_CHANNELS; g++)
    begin : g_cell
        lcm_cell #(
            .NCH   (MAX_CHANNELS),
            .J     (g),
            .ACC_W (ACC_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_ctl      (chain_ctl[g]),
            .in_di_a     (chain_di_a[g]),
            .in_di_b     (chain_di_b[g]),
            .in_lanes_a  (chain_ln_a[g]),
            .in_lanes_b  (chain_ln_b[g]),
            .mean_j      (mean_reg[g]),
            .out_ctl     (chain_ctl[g+1]),
            .out_di_a    (chain_di_a[g+1]),
            .out_di_b    (chain_di_b[g+1]),
            .out_lanes_a (chain_ln_a[g+1]),
            .out_lanes_b (chain_ln_b[g+1]),
            .acc         (cell_acc[g])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, o_col_reg, o_row_reg, o_corr_reg};
    assign m_tuser  = o_err_reg;
    assign m_tlast  = o_last_reg;
endmodule

>>> verif/tb.sv
// Self-checking testbench for the lagged covariance matrix block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lcm_pkg::*;

    localparam int NCH = 8;
    localparam int NSMP = 4096;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic [CORR_W-1:0] corr;
        logic [2:0]        row;
        logic [2:0]        col;
        logic              err;
        logic              last;
    } cov_entry_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;   // [15:0] sample_value
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;   // [47:0] corr_value, [50:48] row_index, [53:51] col_index
    logic                   m_tuser;   // [0] lag_error
    logic                   m_tlast;

    lagged_covariance_matrix_top #(.MAX_CHANNELS(NCH), .MAX_SAMPLES(NSMP)) dut (.*);

    // Shadow of the block state.
    shortint    shadow_store [NSMP][NCH];
    longint     shadow_sum [NCH];
    int         time_pos;
    int         chan_pos;
    logic [3:0]  reg_channels;
    logic [12:0] reg_samples;
    logic [11:0] reg_lag;
    logic        reg_center;

    cov_entry_t expected_entries[$];
    int  mismatch_count;
    int  items_sent;
    int  hold_request;
    bit  no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [15:0] draw_sample();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 16'h8000;
        if (pick == 1)
            return 16'h7fff;
        return 16'($urandom);
    endfunction

    function automatic void restart_block();
        for (int c = 0; c < NCH; c++)
            shadow_sum[c] = 0;
        time_pos = 0;
        chan_pos = 0;
    endfunction

    function automatic logic [CORR_W-1:0] covariance_entry(int i, int j, int span,
                                                           longint mean[NCH]);
        logic signed [127:0] acc;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic [127:0]        q;
        logic                neg;
        acc = 0;
        for (int t = 0; t < span; t++)
        begin
            a = longint'(shadow_store[t][i]) * 65536 - mean[i];
            b = longint'(shadow_store[t + reg_lag][j]) * 65536 - mean[j];
            acc += a * b;
            a = longint'(shadow_store[t][j]) * 65536 - mean[j];
            b = longint'(shadow_store[t + reg_lag][i]) * 65536 - mean[i];
            acc += a * b;
        end
        neg = acc < 0;
        q = neg ? -acc : acc;
        q = (q / span) >> FRAC_SHIFT;
        if (neg)
        begin
            if (q > 128'(CORR_NEG_MAG))
                q = 128'(CORR_NEG_MAG);
            return CORR_W'(-q);
        end
        if (q > 128'(CORR_POS_MAX))
            q = 128'(CORR_POS_MAX);
        return CORR_W'(q);
    endfunction

    // Takes one accepted sample and queues the matrix when a block completes.
    function automatic void absorb_sample(logic [15:0] raw);
        int         nch;
        int         nsmp;
        longint     mean[NCH];
        cov_entry_t e;
        nch = (reg_channels == 0) ? 1 : (reg_channels > NCH) ? NCH : int'(reg_channels);
        nsmp = (reg_samples == 0) ? 1 : (reg_samples > NSMP) ? NSMP : int'(reg_samples);
        shadow_store[time_pos][chan_pos] = shortint'(raw);
        shadow_sum[chan_pos] += longint'(shortint'(raw));
        if (chan_pos + 1 < nch)
        begin
            chan_pos++;
            return;
        end
        chan_pos = 0;
        if (time_pos + 1 < nsmp)
        begin
            time_pos++;
            return;
        end
        for (int c = 0; c < NCH; c++)
            mean[c] = (reg_center && c < nch) ? (shadow_sum[c] * 65536) / longint'(nsmp) : 0;
        for (int i = 0; i < nch; i++)
        begin
            for (int j = 0; j < nch; j++)
            begin
                e.err = (reg_lag >= nsmp);
                e.corr = e.err ? '0 : covariance_entry(i, j, nsmp - int'(reg_lag), mean);
                e.row = 3'(i);
                e.col = 3'(j);
                e.last = (i == nch - 1) && (j == nch - 1);
                expected_entries.push_back(e);
            end
        end
        restart_block();
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_sample(logic [15:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do
            @(posedge clk);
        while (!s_tready);
        absorb_sample(value);
        items_sent++;
    endtask

    task automatic send_block(int count);
        for (int k = 0; k < count; k++)
            send_sample(draw_sample());
    endtask

    // Drops valid at the edge of the last accepted item so it is not taken twice, then waits for all expected entries.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CHANNEL_COUNT:
            begin
                reg_channels = 4'(value);
                restart_block();
            end
            REG_SAMPLE_COUNT:
            begin
                reg_samples = 13'(value);
                restart_block();
            end
            REG_LAG:           reg_lag = 12'(value);
            REG_CENTER_ENABLE: reg_center = 1'(value);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic setup(int ch, int ns, int lg, int ctr);
        wait_drained();
        write_reg(REG_CHANNEL_COUNT, ch);
        write_reg(REG_SAMPLE_COUNT, ns);
        write_reg(REG_LAG, lg);
        write_reg(REG_CENTER_ENABLE, ctr);
    endtask

    task automatic test_extremes();
        setup(2, 4, 1, 1);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        setup(2, 3, 0, 0);
        send_block(6);
        setup(1, 2, 2, 1);      // lag equal to the sample count
        send_block(2);
        setup(0, 0, 0, 1);      // zero counts act as one
        send_block(1);
        setup(15, 2, 4095, 0);  // oversize count acts as eight channels
        send_block(16);
    endtask

    task automatic test_large_block();
        setup(8, 3, 1, 1);
        no_idle = 1'b1;
        send_block(24);
        no_idle = 1'b0;
    endtask

    task automatic test_midblock_writes();
        setup(2, 3, 1, 1);
        send_block(3);
        wait_drained();
        write_reg(REG_CHANNEL_COUNT, 2);   // drops the partial block
        send_block(2);
        wait_drained();
        write_reg(REG_LAG, 2);             // applies at the end of this block
        write_reg(REG_CENTER_ENABLE, 0);
        send_block(4);
    endtask

    task automatic test_backpressure();
        setup(3, 4, 1, 1);
        hold_request = 400;
        no_idle = 1'b1;
        send_block(36);
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        int ch;
        int ns;
        while (items_sent < 120)
        begin
            ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
            ns = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 5);
            setup(ch, ns, ($urandom_range(0, 5) == 0) ? $urandom_range(ns, 4095)
                                                     : $urandom_range(0, ns), $urandom_range(0, 1));
            no_idle = ($urandom_range(0, 4) == 0);
            send_block(((ch == 0) ? 1 : (ch > NCH) ? NCH : ch) * ((ns == 0) ? 1 : ns));
            no_idle = 1'b0;
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else
            begin
                gap = draw_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                do
                    @(posedge clk);
                while (!m_tvalid);
            end
        end
    end

    always @(posedge clk)
    begin
        cov_entry_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_entries.size() == 0)
                report_mismatch("unexpected entry", m_tdata, '0);
            else
            begin
                e = expected_entries.pop_front();
                if (m_tdata[47:0] !== e.corr)
                    report_mismatch("corr_value", m_tdata[47:0], e.corr);
                if (m_tdata[50:48] !== e.row)
                    report_mismatch("row_index", m_tdata[50:48], e.row);
                if (m_tdata[53:51] !== e.col)
                    report_mismatch("col_index", m_tdata[53:51], e.col);
                if (m_tuser !== e.err)
                    report_mismatch("lag_error", m_tuser, e.err);
                if (m_tlast !== e.last)
                    report_mismatch("last_entry", m_tlast, e.last);
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatch_count = 0;
        items_sent = 0;
        hold_request = 0;
        no_idle = 1'b0;
        reg_channels = 4'd2;
        reg_samples = 13'd4096;
        reg_lag = 12'd1;
        reg_center = 1'b1;
        restart_block();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_midblock_writes();
        test_backpressure();
        test_large_block();
        test_random();
        wait_drained();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
src/lcm_pkg.sv
src/lcm_ram.sv
src/lcm_div.sv
src/lcm_cell.sv
src/lagged_covariance_matrix_top.sv
verif/tb.sv
